// File: sv/ffa_pkg.sv
// shared constants, codes and state type for the first-fit frame allocator
// no dependencies; imported by first_fit_frame_allocator and its testbench

package ffa_pkg;

    // store geometry
    localparam int FRAMES     = 512;
    localparam int MAX_RUN    = 16;
    localparam int IDX_W      = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int PAGE_SHIFT = 12;

    // field widths
    localparam int RUN_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int FC_W        = 10;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // command codes (tuser)
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_OOM = 1'b1;

    // configuration register indexes
    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_BASE_ADDR   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } t_state;

endpackage

// File: sv/first_fit_frame_allocator.sv
// first-fit contiguous page frame allocator with a one-bit-per-frame used map
// depends on ffa_pkg
//
// Input beats arrive on s_axis: tuser carries the command (allocate or free),
// tdata carries the run length and the frame address to free. Each beat gives
// exactly one result beat on m_axis: out-of-memory status and the address of
// the first allocated frame (zero on a failed allocate and on every free).
// Configuration (frame count, base address) goes through the plain write port
// and is taken at any edge with i_cfg_we high; change it only while idle.
// After reset the used map is cleared one frame per cycle, during which
// s_axis_tready stays low; configuration writes are taken as usual.
// An allocate reads the used map one frame per cycle through its single read
// port to find the first free run, then marks the run in the used map, hands
// the result over to the output register and returns to idle, the result beat
// going valid as s_axis_tready rises. A free, or an allocate refused before
// the scan, skips the scan and hands its result over the same way.
// s_axis_tready is high only between requests. The result sits in an output
// register, so the next request is accepted while a result waits; a stalled
// receiver holds a finished request in its last state until the register frees.

module first_fit_frame_allocator
    import ffa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [4:0] page_count, [36:5] address
    input  logic                   s_axis_tuser,   // [0] command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] status, [32:1] frame_address
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [ADDR_W-1:0]      i_cfg_data
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [RUN_W-1:0]    r_want, n_want;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [RUN_W-1:0]    r_run, n_run;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_start, n_start;
    logic [RUN_W-1:0]    r_cnt, n_cnt;
    logic                r_status, n_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_out_valid, n_out_valid;
    logic                r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [FC_W-1:0]     r_frame_count;
    logic [ADDR_W-1:0]   r_base;

    logic                r_frame_used [FRAMES];
    logic                r_rd_data;

    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_wa;
    logic                w_mem_wd;
    logic                w_mem_re;
    logic [IDX_W-1:0]    w_mem_ra;

    logic [CNT_W-1:0]    w_active;
    logic                w_want_ok;
    logic                w_issue;
    logic                w_found;
    logic [RUN_W-1:0]    w_run_inc;
    logic [CNT_W-1:0]    w_start_full;
    logic [ADDR_W-1:0]   w_off;
    logic                w_off_hit;

    assign w_active = (32'(r_frame_count) > 32'(FRAMES)) ? CNT_W'(FRAMES)
                                                         : CNT_W'(r_frame_count);
    assign w_want_ok = (r_want != '0) ? 1'b1 : 1'b0;
    assign w_issue   = (r_idx < w_active);
    assign w_run_inc = RUN_W'(r_run + 1'b1);
    assign w_found   = r_pend && !r_rd_data && (w_run_inc == r_want);
    // the frame just checked is r_idx - 1, so the run starts at r_idx - want
    assign w_start_full = CNT_W'(r_idx - CNT_W'(r_want));
    assign w_off     = r_addr - r_base;
    assign w_off_hit = (w_off[PAGE_SHIFT-1:0] == '0) &&
                       (w_off[ADDR_W-1:PAGE_SHIFT] < (ADDR_W-PAGE_SHIFT)'(w_active));

    logic w_want_in_range;
    assign w_want_in_range = (s_axis_tdata[RUN_W-1:0] != '0) &&
                             (32'(s_axis_tdata[RUN_W-1:0]) <= 32'(MAX_RUN));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_addr, r_out_status});

    // used map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_frame_used[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_data <= r_frame_used[w_mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_idx         <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_frame_count <= '0;
            r_base        <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FC_W-1:0];
                    CFG_BASE_ADDR:   r_base        <= i_cfg_data;
                    default:         r_base        <= r_base;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_addr       <= n_addr;
        r_run        <= n_run;
        r_start      <= n_start;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_want       = r_want;
        n_addr       = r_addr;
        n_run        = r_run;
        n_pend       = 1'b0;
        n_start      = r_start;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        w_mem_we     = 1'b0;
        w_mem_wa     = r_idx[IDX_W-1:0];
        w_mem_wd     = 1'b0;
        w_mem_re     = 1'b0;
        w_mem_ra     = r_idx[IDX_W-1:0];

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
                w_mem_wd = 1'b0;
                n_idx    = CNT_W'(r_idx + 1'b1);
                if (r_idx == CNT_W'(FRAMES - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_want     = s_axis_tdata[RUN_W-1:0];
                    n_addr     = s_axis_tdata[RUN_W+ADDR_W-1:RUN_W];
                    n_idx      = '0;
                    n_run      = '0;
                    n_status   = STAT_OK;
                    n_res_addr = '0;
                    if (s_axis_tuser == CMD_FREE) begin
                        n_state = ST_FREE;
                    end else if (w_want_in_range && (w_active != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_status = STAT_OOM;
                        n_state  = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // read one frame ahead, judge the one read last cycle
                w_mem_re = w_issue;
                n_pend   = w_issue;
                if (w_issue) begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
                if (r_pend) begin
                    n_run = r_rd_data ? '0 : w_run_inc;
                end
                if (w_found && w_want_ok) begin
                    n_start    = w_start_full[IDX_W-1:0];
                    n_res_addr = r_base + (ADDR_W'(w_start_full) << PAGE_SHIFT);
                    n_cnt      = r_want;
                    n_pend     = 1'b0;
                    n_state    = ST_MARK;
                end else if (!w_issue) begin
                    n_status = STAT_OOM;
                    n_state  = ST_DONE;
                end
            end
            ST_MARK: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_start;
                w_mem_wd = 1'b1;
                n_start  = IDX_W'(r_start + 1'b1);
                n_cnt    = RUN_W'(r_cnt - 1'b1);
                if (r_cnt == RUN_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE: begin
                w_mem_we = w_off_hit;
                w_mem_wa = w_off[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
                w_mem_wd = 1'b0;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_res_addr;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= w_active))
        else $error("scan pointer past active frames");

    a_mark_sets_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && w_mem_wd) |-> (r_state == ST_MARK))
        else $error("used bit set outside run marking");

    a_oom_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STAT_OOM)) |-> (r_out_addr == '0))
        else $error("out-of-memory result with nonzero address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != ST_IDLE))
        else $error("accepted beat left no work in flight");

endmodule

// File: tb/first_fit_frame_allocator_tb.sv
// self-checking testbench for first_fit_frame_allocator: stream requests in, results checked
// against a bitmap model of the frame store kept in a small scoreboard class
// depends on ffa_pkg and first_fit_frame_allocator
`timescale 1ns / 100ps

module first_fit_frame_allocator_tb;
    import ffa_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] frame_address;
    } t_alloc_result;

    // bitmap model of the allocator plus the queue of results still owed by the block
    class t_frame_ledger;
        bit                frame_used [FRAMES];
        logic [FC_W-1:0]   frame_count;
        logic [ADDR_W-1:0] base_address;
        t_alloc_result     expected_results [$];
        int                errors;

        function new();
            foreach (frame_used[i]) frame_used[i] = 1'b0;
            frame_count  = '0;
            base_address = '0;
            errors       = 0;
        endfunction

        function int active_frames();
            return (frame_count > FRAMES) ? FRAMES : int'(frame_count);
        endfunction

        function void note_request(logic cmd, logic [RUN_W-1:0] run_len,
                                   logic [ADDR_W-1:0] addr);
            t_alloc_result     res;
            int                n;
            int                run;
            int                first;
            bit                found;
            logic [ADDR_W-1:0] offset;
            n     = active_frames();
            run   = 0;
            first = 0;
            found = 1'b0;
            res.status        = STAT_OK;
            res.frame_address = '0;
            if (cmd == CMD_ALLOC) begin
                if (run_len >= 1 && run_len <= MAX_RUN) begin
                    for (int i = 0; i < n; i++) begin
                        if (!frame_used[i]) begin
                            run++;
                            if (run == run_len) begin
                                first = i + 1 - run_len;
                                found = 1'b1;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    for (int k = 0; k < run_len; k++) frame_used[first + k] = 1'b1;
                    res.frame_address = base_address + (ADDR_W'(first) << PAGE_SHIFT);
                end else begin
                    res.status = STAT_OOM;
                end
            end else begin
                // free only hits an exact frame address inside the managed range
                offset = addr - base_address;
                if (offset[PAGE_SHIFT-1:0] == '0 && (offset >> PAGE_SHIFT) < n)
                    frame_used[offset >> PAGE_SHIFT] = 1'b0;
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic status, logic [ADDR_W-1:0] frame_address);
            t_alloc_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat status %0d frame_address %h",
                         $time, status, frame_address);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                errors++;
            end
            if (frame_address !== want.frame_address) begin
                $display("%0t: frame_address expected %h got %h",
                         $time, want.frame_address, frame_address);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_idx     = 1'b0;
    logic [ADDR_W-1:0]      i_cfg_data    = '0;

    t_frame_ledger ledger = new();
    bit            no_stalls = 1'b0;
    int            ready_hold = 0;
    int            cycle_count = 0;

    first_fit_frame_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stalls) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check every accepted beat, stall tready at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tdata[0], m_axis_tdata[ADDR_W:1]);
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ready_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // tvalid from the previous beat is only dropped when a gap follows
    task automatic send_request(logic cmd, logic [RUN_W-1:0] run_len, logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, addr, run_len};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_request(cmd, run_len, addr);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (ledger.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_COUNT)
            ledger.frame_count = value[FC_W-1:0];
        else
            ledger.base_address = value;
        @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] frame_addr_of(int idx);
        return ledger.base_address + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

    task automatic random_request();
        int                n;
        int                idx;
        int                pick;
        logic [RUN_W-1:0]  run_len;
        logic [ADDR_W-1:0] addr;
        n    = ledger.active_frames();
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 99) < 8)
                run_len = RUN_W'($urandom_range(0, 31));
            else if ($urandom_range(0, 99) < 60)
                run_len = RUN_W'($urandom_range(1, 4));
            else
                run_len = RUN_W'($urandom_range(1, MAX_RUN));
            send_request(CMD_ALLOC, run_len, $urandom);
        end else begin
            run_len = RUN_W'($urandom_range(0, 31));
            idx     = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 7);
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                // mostly free a frame that is really in use
                for (int j = 0; j < n; j++) begin
                    if (ledger.frame_used[(idx + j) % n]) begin
                        idx = (idx + j) % n;
                        break;
                    end
                end
                addr = frame_addr_of(idx);
            end else if (pick < 80) begin
                addr = frame_addr_of($urandom_range(0, n + 4));
            end else if (pick < 90) begin
                addr = frame_addr_of(idx) + $urandom_range(1, 4095);
            end else begin
                addr = $urandom;
            end
            send_request(CMD_FREE, run_len, addr);
        end
    endtask

    task automatic run_phase(logic [FC_W-1:0] frames, logic [ADDR_W-1:0] base, int count,
                             bit calm);
        wait_idle();
        write_reg(CFG_FRAME_COUNT, ADDR_W'(frames));
        write_reg(CFG_BASE_ADDR, base);
        no_stalls = calm;
        repeat (count) random_request();
    endtask

    initial begin
        logic [ADDR_W-1:0] b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: nothing managed
        send_request(CMD_ALLOC, 1, 32'h0);
        send_request(CMD_FREE, 0, 32'h0);
        wait_idle();
        write_reg(CFG_FRAME_COUNT, 16);
        write_reg(CFG_BASE_ADDR, 32'h8000_0000);
        b = 32'h8000_0000;
        send_request(CMD_ALLOC, 0, 32'hFFFF_FFFF);     // zero-length run
        send_request(CMD_ALLOC, 17, 32'h0);            // just over the longest run
        send_request(CMD_ALLOC, 31, 32'h0);
        send_request(CMD_ALLOC, 16, 32'h0);            // fills every frame, ends at the last
        send_request(CMD_ALLOC, 1, 32'h0);             // full
        send_request(CMD_FREE, 31, b + 32'h5000);
        send_request(CMD_FREE, 0, b + 32'h5000);       // already free
        send_request(CMD_FREE, 0, b + 32'h6004);       // not page aligned
        send_request(CMD_FREE, 0, b + 32'h1_0000);     // one past the last frame
        send_request(CMD_FREE, 0, b - 32'h1000);       // below the base
        send_request(CMD_FREE, 0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 1, 32'h0);
        send_request(CMD_FREE, 0, b + 32'hF000);
        send_request(CMD_FREE, 0, b + 32'hE000);
        send_request(CMD_ALLOC, 2, 32'h0);             // run ending at the last frame
        send_request(CMD_ALLOC, 1, 32'h0);
        wait_idle();
        write_reg(CFG_FRAME_COUNT, 0);
        send_request(CMD_ALLOC, 1, 32'h0);
        send_request(CMD_FREE, 0, b);

        run_phase(1, 32'h0, 40, 1'b0);
        run_phase(17, 32'hFFFF_F000, 120, 1'b0);     // frames wrap past the top of memory
        run_phase(40, 32'h1234_5678, 150, 1'b0);     // base not page aligned
        run_phase(64, $urandom & 32'hFFFF_F000, 150, 1'b1);
        run_phase(512, 32'h0010_0000, 80, 1'b0);
        run_phase(10'h3FF, $urandom, 60, 1'b0);      // over the store depth
        run_phase(100, $urandom, 150, 1'b0);
        run_phase(24, 32'h0, 150, 1'b0);
        run_phase(0, $urandom, 30, 1'b0);
        run_phase(FC_W'($urandom_range(8, 48)), $urandom, 120, 1'b0);

        no_stalls = 1'b0;
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
